>>> rtl/keyframe_bezier_interpolator_top_assert.svh
// Assertion macros for the keyframe interpolator.
// Uses i_clk and i_rst_n of the module that includes this header.
`ifndef KEYFRAME_BEZIER_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_BEZIER_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define KBI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kbi_pkg.sv
// Shared types, constants and helpers of the keyframe interpolator.
// No dependencies.
package kbi_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    localparam int TIME_W      = 16;
    localparam int CTRL_W      = 16;
    localparam int LANE_W      = 32;
    localparam int ROW_FIXED_W = TIME_W + 2 * CTRL_W;
    localparam int LANE_PORTS  = 4;
    localparam int TOTAL_W     = 7;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Multiply schedule of one evaluate
    localparam logic [3:0] STEP_UU     = 4'd0;
    localparam logic [3:0] STEP_TT     = 4'd1;
    localparam logic [3:0] STEP_UUT    = 4'd2;
    localparam logic [3:0] STEP_TTU    = 4'd3;
    localparam logic [3:0] STEP_TTT    = 4'd4;
    localparam logic [3:0] STEP_W1C1   = 4'd5;
    localparam logic [3:0] STEP_W2C2   = 4'd6;
    localparam logic [3:0] STEP_BUBBLE = 4'd7;
    localparam logic [3:0] STEP_LANE0  = 4'd8;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    function automatic logic [31:0] sat32(input logic [40:0] s);
        logic [31:0] r;
        if (!s[40] && (|s[39:31])) begin
            r = 32'h7FFF_FFFF;
        end else if (s[40] && !(&s[39:31])) begin
            r = 32'h8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/kbi_in_if.sv
// Request channel of the keyframe interpolator: valid/ready plus key fields.
// No dependencies.
interface kbi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [15:0]        frame_time;
    logic [5:0]         key_index;
    logic signed [31:0] lane_in_0;
    logic signed [31:0] lane_in_1;
    logic signed [31:0] lane_in_2;
    logic signed [31:0] lane_in_3;
    logic signed [15:0] ease_ctrl_one;
    logic signed [15:0] ease_ctrl_two;

    modport source (output valid, opcode, frame_time, key_index, lane_in_0, lane_in_1,
                    lane_in_2, lane_in_3, ease_ctrl_one, ease_ctrl_two, input ready);
    modport sink (input valid, opcode, frame_time, key_index, lane_in_0, lane_in_1,
                  lane_in_2, lane_in_3, ease_ctrl_one, ease_ctrl_two, output ready);
endinterface

>>> rtl/kbi_out_if.sv
// Result channel of the keyframe interpolator: valid/ready plus result fields.
// No dependencies.
interface kbi_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [6:0]         key_total;
    logic signed [31:0] lane_out_0;
    logic signed [31:0] lane_out_1;
    logic signed [31:0] lane_out_2;
    logic signed [31:0] lane_out_3;

    modport source (output valid, status, key_total, lane_out_0, lane_out_1, lane_out_2,
                    lane_out_3, input ready);
    modport sink (input valid, status, key_total, lane_out_0, lane_out_1, lane_out_2,
                  lane_out_3, output ready);
endinterface

>>> rtl/keyframe_bezier_interpolator_top.sv
// Keyframe table with cubic Bezier ease between neighboring keys.
// Depends on kbi_pkg, kbi_in_if, kbi_out_if, kbi_key_mem, kbi_div, kbi_mul.
//
//   channel | dir | contents
//   i_in    | in  | opcode, frame_time, key_index, lane_in_0..3, ease_ctrl_one/two
//   o_out   | out | status, key_total, lane_out_0..3
//
// One transaction at a time; i_in.ready is high only while idle and out of reset.
// Insert/delete move one table row a cycle through the table memory.
// Evaluate scans one row a cycle (up to key count), then a setup step, the divider
// (skipped for a query at or before the earlier key, or for a zero span) and the
// shared multiplier.
// The result waits in an output register; a stalled output holds the next request.
// Reset is synchronous and empties the table at once.
module keyframe_bezier_interpolator_top import kbi_pkg::*; #(
    parameter int MAX_KEYS = 64,
    parameter int LANES    = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbi_in_if.sink    i_in,
    kbi_out_if.source o_out
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int RW = ROW_FIXED_W + LANES * LANE_W;
    localparam int XW = CW + 6;
    localparam logic [3:0] STEP_LAST = 4'(STEP_LANE0 + LANES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_INS0, S_DEL, S_SCAN, S_PREP, S_DIV, S_MUL, S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [15:0]        r_ft;
    logic [RW-1:0]      r_new;
    logic [AW-1:0]      r_pos;
    logic [RW-1:0]      r_prev;
    logic [RW-1:0]      r_pre;
    logic [RW-1:0]      r_nxt;
    t_status            r_status;
    logic [16:0]        r_t;
    logic [16:0]        r_u;
    logic [33:0]        r_uu;
    logic [33:0]        r_tt;
    logic [17:0]        r_w1;
    logic [17:0]        r_w2;
    logic [17:0]        r_w3;
    logic signed [MUL_P_W-1:0] r_acc;
    logic signed [MUL_B_W-1:0] r_e;
    logic [3:0]         r_step;
    logic [3:0]         r_ptag;
    logic               r_pv;
    logic [31:0]        r_lane [LANE_PORTS];
    logic               r_ovalid;
    t_status            r_ostatus;
    logic [TOTAL_W-1:0] r_ototal;
    logic [31:0]        r_olane [LANE_PORTS];

    logic               w_accept;
    t_opcode            w_op;
    logic [31:0]        w_lane_in [LANE_PORTS];
    logic [RW-1:0]      w_in_row;
    logic [CW-1:0]      w_cnt_m1;
    logic [XW-1:0]      w_idx_ext;
    logic [XW-1:0]      w_cnt_ext;
    logic               w_full;
    logic               w_del_bad;
    logic               w_del_tail;
    logic               w_last;
    logic               w_cnt_one;
    logic [15:0]        w_rd_time;
    logic               w_hit;
    logic               w_ins_move;
    logic [XW-1:0]      w_tot_ext;

    logic               m_we;
    logic [AW-1:0]      m_wa;
    logic [RW-1:0]      m_wd;
    logic               m_re;
    logic [AW-1:0]      m_ra;
    logic [RW-1:0]      m_rd;

    logic [15:0]        w_pre_time;
    logic [15:0]        w_nxt_time;
    logic               w_div_start;
    logic               w_div_done;
    logic [16:0]        w_quot;
    logic [16:0]        w_t_clamp;

    logic               w_mul_en;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [MUL_P_W-1:0] w_prod;
    logic [1:0]         w_ilsel;
    logic [1:0]         w_clsel;
    logic [31:0]        w_ia;
    logic [31:0]        w_ib;
    logic [31:0]        w_ca;
    logic [15:0]        w_c1;
    logic [15:0]        w_c2;
    logic [56:0]        w_p3;
    logic signed [MUL_P_W-1:0] w_esum;
    logic signed [MUL_P_W-1:0] w_eval;
    logic [40:0]        w_lsum;

    // ---------------- input row and table decisions ----------------
    assign w_accept     = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE) && i_rst_n;
    assign w_op         = t_opcode'(i_in.opcode);
    assign w_lane_in[0] = i_in.lane_in_0;
    assign w_lane_in[1] = i_in.lane_in_1;
    assign w_lane_in[2] = i_in.lane_in_2;
    assign w_lane_in[3] = i_in.lane_in_3;

    always_comb begin
        w_in_row = '0;
        w_in_row[TIME_W-1:0] = i_in.frame_time;
        w_in_row[TIME_W +: CTRL_W] = i_in.ease_ctrl_one;
        w_in_row[TIME_W + CTRL_W +: CTRL_W] = i_in.ease_ctrl_two;
        for (int l = 0; l < LANES; l++) begin
            w_in_row[ROW_FIXED_W + l * LANE_W +: LANE_W] = w_lane_in[l];
        end
    end

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_idx_ext  = XW'(i_in.key_index);
    assign w_cnt_ext  = XW'(r_count);
    assign w_full     = (r_count >= CW'(MAX_KEYS));
    assign w_del_bad  = (i_in.key_index == 6'd0) || (w_idx_ext >= w_cnt_ext);
    assign w_del_tail = (w_idx_ext == XW'(w_cnt_m1));
    assign w_last     = (CW'(r_pos) == w_cnt_m1);
    assign w_cnt_one  = (r_count == CW'(1));
    assign w_rd_time  = m_rd[TIME_W-1:0];
    assign w_hit      = (w_rd_time >= r_ft);
    assign w_ins_move = (w_rd_time > r_ft);
    assign w_tot_ext  = XW'(r_count);

    // ---------------- table memory control ----------------
    always_comb begin
        m_we = 1'b0;
        m_wa = '0;
        m_wd = r_new;
        m_re = 1'b0;
        m_ra = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_INSERT: begin
                            if (!w_full && r_count == '0) begin
                                m_we = 1'b1;
                                m_wd = w_in_row;
                            end else if (!w_full) begin
                                m_re = 1'b1;
                                m_ra = AW'(w_cnt_m1);
                            end
                        end
                        OP_DELETE: begin
                            if (!w_del_bad && !w_del_tail) begin
                                m_re = 1'b1;
                                m_ra = AW'(w_idx_ext + XW'(1));
                            end
                        end
                        OP_EVAL: begin
                            m_re = (r_count != '0);
                        end
                        OP_NOP: ;
                    endcase
                end
            end
            S_INS: begin
                // shift the later key up one row, or drop the new key in behind it
                m_we = 1'b1;
                m_wa = r_pos + AW'(1);
                if (w_ins_move) begin
                    m_wd = m_rd;
                    m_re = (r_pos != '0);
                    m_ra = r_pos - AW'(1);
                end
            end
            S_INS0: begin
                m_we = 1'b1;
            end
            S_DEL: begin
                m_we = 1'b1;
                m_wa = r_pos - AW'(1);
                m_wd = m_rd;
                m_re = !w_last;
                m_ra = r_pos + AW'(1);
            end
            S_SCAN: begin
                if (r_pos == '0) begin
                    m_re = !w_cnt_one;
                    m_ra = AW'(1);
                end else begin
                    m_re = !w_hit && !w_last;
                    m_ra = r_pos + AW'(1);
                end
            end
            S_PREP, S_DIV, S_MUL, S_OUT: ;
            default: ;
        endcase
    end

    kbi_key_mem #(.DEPTH(MAX_KEYS), .WIDTH(RW)) u_mem (
        .i_clk (i_clk),
        .i_we  (m_we),
        .i_wa  (m_wa),
        .i_wd  (m_wd),
        .i_re  (m_re),
        .i_ra  (m_ra),
        .o_rd  (m_rd)
    );

    // ---------------- divider ----------------
    assign w_pre_time  = r_pre[TIME_W-1:0];
    assign w_nxt_time  = r_nxt[TIME_W-1:0];
    assign w_div_start = (r_state == S_PREP) && (r_ft > w_pre_time) &&
                         (w_nxt_time > w_pre_time);
    assign w_t_clamp   = (w_quot > ONE_Q16) ? ONE_Q16 : w_quot;

    kbi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_ft - w_pre_time),
        .i_divisor  (w_nxt_time - w_pre_time),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ---------------- shared multiplier ----------------
    assign w_ilsel  = 2'(r_step - STEP_LANE0);
    assign w_clsel  = 2'(r_ptag - STEP_LANE0);
    assign w_ia     = r_pre[ROW_FIXED_W + LANE_W * w_ilsel +: LANE_W];
    assign w_ib     = r_nxt[ROW_FIXED_W + LANE_W * w_ilsel +: LANE_W];
    assign w_ca     = r_pre[ROW_FIXED_W + LANE_W * w_clsel +: LANE_W];
    assign w_c1     = r_nxt[TIME_W +: CTRL_W];
    assign w_c2     = r_nxt[TIME_W + CTRL_W +: CTRL_W];
    assign w_mul_en = (r_state == S_MUL) && (r_step <= STEP_LAST) &&
                      (r_step != STEP_BUBBLE);

    always_comb begin
        unique case (r_step)
            STEP_UU:   begin w_ma = {17'b0, r_u};  w_mb = {5'b0, r_u}; end
            STEP_TT:   begin w_ma = {17'b0, r_t};  w_mb = {5'b0, r_t}; end
            STEP_UUT:  begin w_ma = r_uu;          w_mb = {5'b0, r_t}; end
            STEP_TTU:  begin w_ma = r_tt;          w_mb = {5'b0, r_u}; end
            STEP_TTT:  begin w_ma = r_tt;          w_mb = {5'b0, r_t}; end
            STEP_W1C1: begin w_ma = {16'b0, r_w1}; w_mb = {{6{w_c1[15]}}, w_c1}; end
            STEP_W2C2: begin w_ma = {16'b0, r_w2}; w_mb = {{6{w_c2[15]}}, w_c2}; end
            default: begin
                w_ma = {{2{w_ib[31]}}, w_ib} - {{2{w_ia[31]}}, w_ia};
                w_mb = r_e;
            end
        endcase
    end

    kbi_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_p3   = {w_prod, 1'b0} + {1'b0, w_prod};
    assign w_esum = r_acc + w_prod;
    assign w_eval = (w_esum >>> 14) + $signed({38'b0, r_w3});
    assign w_lsum = {{9{w_ca[31]}}, w_ca} + {w_prod[MUL_P_W-1], w_prod[MUL_P_W-1:16]};

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pv   <= w_mul_en;
            r_ptag <= r_step;
            if (r_ovalid && o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ft     <= i_in.frame_time;
                        r_new    <= w_in_row;
                        r_status <= ST_OK;
                        for (int l = 0; l < LANE_PORTS; l++) begin
                            r_lane[l] <= '0;
                        end
                        unique case (w_op)
                            OP_INSERT: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else if (r_count == '0) begin
                                    r_count <= r_count + CW'(1);
                                    r_state <= S_OUT;
                                end else begin
                                    r_pos   <= AW'(w_cnt_m1);
                                    r_state <= S_INS;
                                end
                            end
                            OP_DELETE: begin
                                if (w_del_bad) begin
                                    r_status <= ST_REFUSED;
                                    r_state  <= S_OUT;
                                end else if (w_del_tail) begin
                                    r_count <= w_cnt_m1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_pos   <= AW'(w_idx_ext + XW'(1));
                                    r_state <= S_DEL;
                                end
                            end
                            OP_EVAL: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_pos   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_NOP: r_state <= S_OUT;
                        endcase
                    end
                end
                S_INS: begin
                    if (!w_ins_move) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end else if (r_pos == '0) begin
                        r_state <= S_INS0;
                    end else begin
                        r_pos <= r_pos - AW'(1);
                    end
                end
                S_INS0: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end
                S_DEL: begin
                    if (w_last) begin
                        r_count <= w_cnt_m1;
                        r_state <= S_OUT;
                    end else begin
                        r_pos <= r_pos + AW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_pos == '0) begin
                        r_prev <= m_rd;
                        if (w_cnt_one) begin
                            r_pre   <= m_rd;
                            r_nxt   <= m_rd;
                            r_state <= S_PREP;
                        end else begin
                            r_pos <= AW'(1);
                        end
                    end else if (w_hit) begin
                        r_pre   <= r_prev;
                        r_nxt   <= m_rd;
                        r_state <= S_PREP;
                    end else if (w_last) begin
                        r_pre   <= m_rd;
                        r_nxt   <= m_rd;
                        r_state <= S_PREP;
                    end else begin
                        r_prev <= m_rd;
                        r_pos  <= r_pos + AW'(1);
                    end
                end
                S_PREP: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        // query at or before the previous key, or a zero span
                        r_e     <= (r_ft > w_pre_time) ? MUL_B_W'(ONE_Q16) : '0;
                        r_step  <= STEP_LANE0;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= w_t_clamp;
                        r_u     <= ONE_Q16 - w_t_clamp;
                        r_step  <= STEP_UU;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    if (r_pv) begin
                        unique case (r_ptag)
                            STEP_UU:   r_uu  <= w_prod[33:0];
                            STEP_TT:   r_tt  <= w_prod[33:0];
                            STEP_UUT:  r_w1  <= w_p3[49:32];
                            STEP_TTU:  r_w2  <= w_p3[49:32];
                            STEP_TTT:  r_w3  <= w_prod[49:32];
                            STEP_W1C1: r_acc <= w_prod;
                            STEP_W2C2: r_e   <= w_eval[MUL_B_W-1:0];
                            default: begin
                                r_lane[w_clsel] <= sat32(w_lsum);
                                if (w_clsel == 2'(LANES - 1)) begin
                                    r_state <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_ototal  <= w_tot_ext[TOTAL_W-1:0];
                        r_olane   <= r_lane;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_ostatus;
    assign o_out.key_total  = r_ototal;
    assign o_out.lane_out_0 = r_olane[0];
    assign o_out.lane_out_1 = r_olane[1];
    assign o_out.lane_out_2 = r_olane[2];
    assign o_out.lane_out_3 = r_olane[3];

    `include "keyframe_bezier_interpolator_top_assert.svh"

    `KBI_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(MAX_KEYS), "key count above table size")
    `KBI_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != S_IDLE, "accepted transaction not started")
    `KBI_ASSERT_NEXT(a_idle_count_hold, (r_state == S_IDLE) && !w_accept, $stable(r_count), "key count moved while idle")
    `KBI_ASSERT_NOW(a_product_in_mul, r_pv, r_state == S_MUL, "product pending outside multiply phase")
    `KBI_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == S_DIV, "divider finished outside divide phase")

endmodule

>>> rtl/kbi_key_mem.sv
// Key table memory: one write port, one read port with registered data.
// No dependencies.
module kbi_key_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 176
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;
endmodule

>>> rtl/kbi_div.sv
// Restoring divider for the ease parameter t = d * 2^16 / s, one bit a cycle.
// Assumes 0 < d <= s; depends on nothing else.
module kbi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [17:0] r_rem;
    logic [15:0] r_div;
    logic [16:0] r_quot;
    logic        w_ge;
    logic [17:0] w_diff;
    logic [17:0] w_keep;

    assign w_ge   = r_rem >= {2'b00, r_div};
    assign w_diff = r_rem - {2'b00, r_div};
    assign w_keep = w_ge ? w_diff : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_rem  <= {2'b00, i_dividend};
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_quot <= {r_quot[15:0], w_ge};
                r_rem  <= {w_keep[16:0], 1'b0};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/kbi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on kbi_pkg for operand widths.
module kbi_mul import kbi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);
    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule
